// ===== rtl/tsac_pkg.sv =====
package tsac_pkg;

   // field widths
   localparam int RAW_W    = 12;
   localparam int PIX_W    = 11;
   localparam int SIZE_W   = 12;
   localparam int NUM_SAMP = 5;
   localparam int SUM_W    = 15;
   localparam int NUM_W    = 23;
   localparam int QUOT_W   = 12;
   localparam int RECIP_W  = 28;
   localparam int YPIX_W   = 13;
   localparam int NUM_YSEG = 4;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd320;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [SIZE_W-1:0] SIZE_MAX     = 12'd2048;

   // calibration points
   localparam int RAW_X_LO = 730;
   localparam int RAW_X_HI = 3405;
   localparam int CAL_Y0   = 3516;
   localparam int CAL_Y1   = 2759;
   localparam int CAL_Y2   = 2008;
   localparam int CAL_Y3   = 1253;
   localparam int CAL_Y4   = 1058;
   localparam int PIX_Y1   = 120;
   localparam int PIX_Y2   = 240;
   localparam int PIX_Y3   = 360;
   localparam int PIX_Y4   = 479;

   localparam int RAW_X_SPAN = RAW_X_HI - RAW_X_LO;
   localparam int Y_SPAN_0   = CAL_Y0 - CAL_Y1;
   localparam int Y_SPAN_1   = CAL_Y1 - CAL_Y2;
   localparam int Y_SPAN_2   = CAL_Y2 - CAL_Y3;
   localparam int Y_SPAN_3   = CAL_Y3 - CAL_Y4;

   // reciprocal division: q = (n * ceil(2^k / d)) >> k, exact over the numerator range
   localparam int RECIP_SHIFT = 35;
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_X =
      RECIP_W'((RECIP_ONE + 64'(RAW_X_SPAN) - 64'd1) / 64'(RAW_X_SPAN));

   localparam int MEAN_SHIFT = 17;
   localparam logic [SUM_W-1:0] RECIP_MEAN =
      SUM_W'(((64'd1 << MEAN_SHIFT) + 64'(NUM_SAMP) - 64'd1) / 64'(NUM_SAMP));

   typedef logic [RAW_W-1:0] raw_arr_type [NUM_YSEG];
   typedef logic [PIX_W-1:0] slope_arr_type [NUM_YSEG];
   typedef logic [RECIP_W-1:0] recip_arr_type [NUM_YSEG];
   typedef logic [QUOT_W-1:0] quot_arr_type [NUM_YSEG];
   typedef logic [YPIX_W-1:0] ypix_arr_type [NUM_YSEG];

   // per segment: raw anchor, pixel rise, reciprocal of raw span, pixel base
   localparam raw_arr_type Y_ANCHOR = '{12'(CAL_Y0), 12'(CAL_Y1), 12'(CAL_Y2), 12'(CAL_Y3)};
   localparam slope_arr_type Y_RISE = '{11'(PIX_Y1), 11'(PIX_Y2 - PIX_Y1),
                                        11'(PIX_Y3 - PIX_Y2), 11'(PIX_Y4 - PIX_Y3)};
   localparam recip_arr_type Y_RECIP = '{
      RECIP_W'((RECIP_ONE + 64'(Y_SPAN_0) - 64'd1) / 64'(Y_SPAN_0)),
      RECIP_W'((RECIP_ONE + 64'(Y_SPAN_1) - 64'd1) / 64'(Y_SPAN_1)),
      RECIP_W'((RECIP_ONE + 64'(Y_SPAN_2) - 64'd1) / 64'(Y_SPAN_2)),
      RECIP_W'((RECIP_ONE + 64'(Y_SPAN_3) - 64'd1) / 64'(Y_SPAN_3))};
   localparam ypix_arr_type Y_BASE = '{13'd0, 13'(PIX_Y1), 13'(PIX_Y2), 13'(PIX_Y3)};

   typedef logic [NUM_SAMP-1:0][RAW_W-1:0] samp_set_type;

   typedef struct packed {
      logic             pen_down_before;
      logic             pen_down_after;
      logic [RAW_W-1:0] x_sample_0;
      logic [RAW_W-1:0] x_sample_1;
      logic [RAW_W-1:0] x_sample_2;
      logic [RAW_W-1:0] x_sample_3;
      logic [RAW_W-1:0] x_sample_4;
      logic [RAW_W-1:0] y_sample_0;
      logic [RAW_W-1:0] y_sample_1;
      logic [RAW_W-1:0] y_sample_2;
      logic [RAW_W-1:0] y_sample_3;
      logic [RAW_W-1:0] y_sample_4;
   } req_word_type;

   typedef struct packed {
      logic             touched;
      logic [PIX_W-1:0] screen_x;
      logic [PIX_W-1:0] screen_y;
   } rsp_word_type;

   // load strobes for the two mapping stages
   typedef struct packed {
      logic mul_ld;
      logic div_ld;
   } lane_en_type;

   // size register to size-1, saturating to 1..2048
   function automatic logic [PIX_W-1:0] size_m1_fn(input logic [SIZE_W-1:0] v);
      logic [PIX_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (v > SIZE_MAX) begin
         r = '1;
      end else begin
         r = PIX_W'(v - 12'd1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/tsac_mean5.sv =====
module tsac_mean5 (
   input  logic                       clock,
   input  logic                       load,
   input  tsac_pkg::samp_set_type     samples,
   output logic [tsac_pkg::RAW_W-1:0] mean
);
   import tsac_pkg::*;

   logic [SUM_W-1:0]   sum_in;
   logic [SUM_W-1:0]   sum_ff;
   logic [2*SUM_W-1:0] prod;

   // adder tree over the five conversions
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NUM_SAMP; i++) begin
         sum_in = sum_in + SUM_W'(samples[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   // divide by five through the reciprocal
   assign prod = sum_ff * RECIP_MEAN;
   assign mean = prod[MEAN_SHIFT +: RAW_W];

endmodule

// ===== rtl/tsac_map_lane.sv =====
module tsac_map_lane (
   input  logic                          clock,
   input  tsac_pkg::lane_en_type         en,
   input  logic [tsac_pkg::RAW_W-1:0]    raw,
   input  logic [tsac_pkg::RAW_W-1:0]    anchor,
   input  logic [tsac_pkg::PIX_W-1:0]    factor,
   input  logic [tsac_pkg::RECIP_W-1:0]  recip,
   output logic [tsac_pkg::QUOT_W-1:0]   quot
);
   import tsac_pkg::*;

   logic [RAW_W-1:0]         gap;
   logic [NUM_W-1:0]         num_in;
   logic [NUM_W-1:0]         num_ff;
   logic [NUM_W+RECIP_W-1:0] prod;
   logic [QUOT_W-1:0]        quot_ff;

   // distance below the anchor; at or above it the pixel is zero
   assign gap    = anchor - raw;
   assign num_in = (raw < anchor) ? NUM_W'(gap * factor) : '0;

   always_ff @(posedge clock) begin
      if (en.mul_ld) begin
         num_ff <= num_in;
      end
   end

   // constant divide by reciprocal multiply
   assign prod = num_ff * recip;

   always_ff @(posedge clock) begin
      if (en.div_ld) begin
         quot_ff <= prod[RECIP_SHIFT +: QUOT_W];
      end
   end

   assign quot = quot_ff;

endmodule

// ===== rtl/tsac_merge.sv =====
module tsac_merge (
   input  logic                        touched,
   input  logic [tsac_pkg::RAW_W-1:0]  raw_y,
   input  logic [tsac_pkg::QUOT_W-1:0] quot_x,
   input  tsac_pkg::quot_arr_type      quot_y,
   input  logic [tsac_pkg::PIX_W-1:0]  width_m1,
   input  logic [tsac_pkg::PIX_W-1:0]  height_m1,
   output tsac_pkg::rsp_word_type      word
);
   import tsac_pkg::*;

   logic [YPIX_W-1:0] pix_y;

   // pick the Y segment holding the raw value
   always_comb begin
      if (raw_y >= Y_ANCHOR[1]) begin
         pix_y = Y_BASE[0] + YPIX_W'(quot_y[0]);
      end else if (raw_y >= Y_ANCHOR[2]) begin
         pix_y = Y_BASE[1] + YPIX_W'(quot_y[1]);
      end else if (raw_y >= Y_ANCHOR[3]) begin
         pix_y = Y_BASE[2] + YPIX_W'(quot_y[2]);
      end else begin
         pix_y = Y_BASE[3] + YPIX_W'(quot_y[3]);
      end
   end

   // clamp to the screen
   always_comb begin
      word.touched  = touched;
      word.screen_x = (quot_x > QUOT_W'(width_m1)) ? width_m1 : PIX_W'(quot_x);
      word.screen_y = (pix_y > YPIX_W'(height_m1)) ? height_m1 : PIX_W'(pix_y);
   end

endmodule

// ===== rtl/touch_sample_average_calibrate.sv =====
// Throughput: one word per cycle while the output is not stalled; five register stages
// (sum, mean, product, reciprocal divide, output) advance independently, so bubbles
// collapse and input is taken while a result waits. Synchronous active-high reset clears
// the held coordinates, the pipeline valids and sets the size registers to 320 x 480.
module touch_sample_average_calibrate (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tsac_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tsac_pkg::rsp_word_type            rsp_word,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tsac_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tsac_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tsac_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import tsac_pkg::*;

   // size registers
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [PIX_W-1:0]  width_m1;
   logic [PIX_W-1:0]  height_m1;
   logic              csr_wr;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic ld1, ld2, ld3, ld4, ld5;
   logic ok1_ff, ok2_ff, ok3_ff, ok4_ff;
   lane_en_type lane_en;

   // data
   samp_set_type      xs, ys;
   logic [RAW_W-1:0]  mean_x, mean_y;
   logic [RAW_W-1:0]  cur_x, cur_y;
   logic [RAW_W-1:0]  held_x_ff, held_y_ff;
   logic [RAW_W-1:0]  raw_x2_ff, raw_y2_ff;
   logic [RAW_W-1:0]  ry3_ff, ry4_ff;
   logic [QUOT_W-1:0] quot_x;
   quot_arr_type      quot_y;
   rsp_word_type      merged;
   rsp_word_type      rsp_word_ff;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            CSR_IDX_WIDTH:  width_in  = pwdata[SIZE_W-1:0];
            CSR_IDX_HEIGHT: height_in = pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         CSR_IDX_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign width_m1  = size_m1_fn(width_ff);
   assign height_m1 = size_m1_fn(height_ff);

   // stage handshake: a stage loads when empty or emptying
   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign ld1  = req_valid && rdy1;
   assign ld2  = v1_ff && rdy2;
   assign ld3  = v2_ff && rdy3;
   assign ld4  = v3_ff && rdy4;
   assign ld5  = v4_ff && rdy5;
   assign req_stall = !rdy1;

   assign lane_en.mul_ld = ld3;
   assign lane_en.div_ld = ld4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= ld1 || (v1_ff && !ld2);
         v2_ff <= ld2 || (v2_ff && !ld3);
         v3_ff <= ld3 || (v3_ff && !ld4);
         v4_ff <= ld4 || (v4_ff && !ld5);
         v5_ff <= ld5 || (v5_ff && rsp_stall);
      end
   end

   // sample sums, one lane per axis
   assign xs = {req_word.x_sample_4, req_word.x_sample_3, req_word.x_sample_2,
                req_word.x_sample_1, req_word.x_sample_0};
   assign ys = {req_word.y_sample_4, req_word.y_sample_3, req_word.y_sample_2,
                req_word.y_sample_1, req_word.y_sample_0};

   tsac_mean5 u_mean_x (
      .clock   (clock),
      .load    (ld1),
      .samples (xs),
      .mean    (mean_x)
   );

   tsac_mean5 u_mean_y (
      .clock   (clock),
      .load    (ld1),
      .samples (ys),
      .mean    (mean_y)
   );

   always_ff @(posedge clock) begin
      if (ld1) begin
         ok1_ff <= req_word.pen_down_before && req_word.pen_down_after;
      end
   end

   // held coordinates: replaced by the means on a valid touch
   assign cur_x = ok1_ff ? mean_x : held_x_ff;
   assign cur_y = ok1_ff ? mean_y : held_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
      end else if (ld2) begin
         held_x_ff <= cur_x;
         held_y_ff <= cur_y;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         raw_x2_ff <= cur_x;
         raw_y2_ff <= cur_y;
         ok2_ff    <= ok1_ff;
      end
      if (ld3) begin
         ry3_ff <= raw_y2_ff;
         ok3_ff <= ok2_ff;
      end
      if (ld4) begin
         ry4_ff <= ry3_ff;
         ok4_ff <= ok3_ff;
      end
   end

   // mapping lanes: X, then one per Y segment
   tsac_map_lane u_lane_x (
      .clock  (clock),
      .en     (lane_en),
      .raw    (raw_x2_ff),
      .anchor (RAW_W'(RAW_X_HI)),
      .factor (width_m1),
      .recip  (RECIP_X),
      .quot   (quot_x)
   );

   for (genvar g = 0; g < NUM_YSEG; g++) begin : g_lane_y
      tsac_map_lane u_lane_y (
         .clock  (clock),
         .en     (lane_en),
         .raw    (raw_y2_ff),
         .anchor (Y_ANCHOR[g]),
         .factor (Y_RISE[g]),
         .recip  (Y_RECIP[g]),
         .quot   (quot_y[g])
      );
   end

   tsac_merge u_merge (
      .touched   (ok4_ff),
      .raw_y     (ry4_ff),
      .quot_x    (quot_x),
      .quot_y    (quot_y),
      .width_m1  (width_m1),
      .height_m1 (height_m1),
      .word      (merged)
   );

   // output register
   always_ff @(posedge clock) begin
      if (ld5) begin
         rsp_word_ff <= merged;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_word  = rsp_word_ff;

   // a rejected scan leaves the held coordinates alone
   a_held_keep: assert property (@(posedge clock) disable iff (reset)
      (ld2 && !ok1_ff) |=> ($stable(held_x_ff) && $stable(held_y_ff)))
      else $error("held coordinates changed on a rejected scan");

   // the word entering the mean stage carries the held values
   a_held_match: assert property (@(posedge clock) disable iff (reset)
      ld2 |=> (raw_x2_ff == held_x_ff && raw_y2_ff == held_y_ff))
      else $error("mean stage disagrees with held coordinates");

   // input is only refused when every stage is full and the output stalls
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // a blocked divide stage keeps its word
   a_stage4_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rdy4) |=> (v4_ff && $stable(ry4_ff) && $stable(quot_x)))
      else $error("divide stage lost its word while blocked");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tsac_pkg::*;

   localparam int NUM_PHASES      = 8;
   localparam int WORDS_PER_PHASE = 185;
   localparam int HOLD_OFF_CYCLES = 40;
   localparam int HOLD_OFF_AT     = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int MAX_REPORTS     = 100;

   localparam logic [CSR_ADDR_W-1:0] ADDR_WIDTH  = {CSR_IDX_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_HEIGHT = {CSR_IDX_HEIGHT, 2'b00};

   // raw values worth aiming noisy samples at
   localparam int CAL_POINTS [7] = '{RAW_X_LO, RAW_X_HI, CAL_Y0, CAL_Y1, CAL_Y2, CAL_Y3, CAL_Y4};

   typedef struct {
      req_word_type scan;
      bit           use_fixed;
      rsp_word_type fixed;
   } scan_row_type;

   typedef struct {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      int unsigned       req_idle_pct;
      int unsigned       rsp_stall_pct;
      bit                hold_off;
   } run_phase_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // model copy of the size registers and the held touch
   logic [SIZE_W-1:0] width_reg    = WIDTH_RESET;
   logic [SIZE_W-1:0] height_reg   = HEIGHT_RESET;
   logic [RAW_W-1:0]  held_x       = '0;
   logic [RAW_W-1:0]  held_y       = '0;
   logic              held_pressed = 1'b0;

   rsp_word_type  expected_pixels [$];
   scan_row_type  directed_rows [$];
   run_phase_type phases [NUM_PHASES];

   int unsigned req_idle_pct  = 13;
   int unsigned rsp_stall_pct = 58;
   bit          hold_off_req  = 1'b0;
   int          mismatch_count = 0;
   int          idle_cycles    = 0;

   touch_sample_average_calibrate u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
      end
   endtask

   // ---------------------------------------------------------------- predictor

   // size register to a pixel count, saturating to 1..2048
   function automatic longint effective_size(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (v > SIZE_MAX) begin
         return 2048;
      end
      return longint'(v);
   endfunction

   function automatic longint clamp_pixel(input longint v, input longint size);
      if (v < 0) begin
         return 0;
      end
      if (v >= size) begin
         return size - 1;
      end
      return v;
   endfunction

   // truncated mean of one axis
   function automatic logic [RAW_W-1:0] mean_of_five(input logic [RAW_W-1:0] a, b, c, d, e);
      int sum;
      sum = int'(a) + int'(b) + int'(c) + int'(d) + int'(e);
      return RAW_W'(sum / NUM_SAMP);
   endfunction

   // four straight segments through the Y calibration points
   function automatic longint map_raw_y(input longint ry);
      if (ry >= CAL_Y1) begin
         return (CAL_Y0 - ry) * PIX_Y1 / (CAL_Y0 - CAL_Y1);
      end
      if (ry >= CAL_Y2) begin
         return PIX_Y1 + (CAL_Y1 - ry) * (PIX_Y2 - PIX_Y1) / (CAL_Y1 - CAL_Y2);
      end
      if (ry >= CAL_Y3) begin
         return PIX_Y2 + (CAL_Y2 - ry) * (PIX_Y3 - PIX_Y2) / (CAL_Y2 - CAL_Y3);
      end
      return PIX_Y3 + (CAL_Y3 - ry) * (PIX_Y4 - PIX_Y3) / (CAL_Y3 - CAL_Y4);
   endfunction

   // one scan: update the held touch, then map it to screen pixels
   function automatic rsp_word_type calibrate_scan(input req_word_type s);
      rsp_word_type r;
      longint       w;
      longint       h;
      longint       sx;
      longint       sy;
      w = effective_size(width_reg);
      h = effective_size(height_reg);
      if (s.pen_down_before && s.pen_down_after) begin
         held_x = mean_of_five(s.x_sample_0, s.x_sample_1, s.x_sample_2,
                               s.x_sample_3, s.x_sample_4);
         held_y = mean_of_five(s.y_sample_0, s.y_sample_1, s.y_sample_2,
                               s.y_sample_3, s.y_sample_4);
         held_pressed = 1'b1;
      end else begin
         held_pressed = 1'b0;
      end
      sx = (longint'(RAW_X_HI) - longint'(held_x)) * (w - 1) / longint'(RAW_X_HI - RAW_X_LO);
      sy = map_raw_y(longint'(held_y));
      r.touched  = held_pressed;
      r.screen_x = PIX_W'(clamp_pixel(sx, w));
      r.screen_y = PIX_W'(clamp_pixel(sy, h));
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic req_word_type uniform_scan(input bit before_down, input bit after_down,
                                                 input int x, input int y);
      req_word_type s;
      s.pen_down_before = before_down;
      s.pen_down_after  = after_down;
      s.x_sample_0 = RAW_W'(x);
      s.x_sample_1 = RAW_W'(x);
      s.x_sample_2 = RAW_W'(x);
      s.x_sample_3 = RAW_W'(x);
      s.x_sample_4 = RAW_W'(x);
      s.y_sample_0 = RAW_W'(y);
      s.y_sample_1 = RAW_W'(y);
      s.y_sample_2 = RAW_W'(y);
      s.y_sample_3 = RAW_W'(y);
      s.y_sample_4 = RAW_W'(y);
      return s;
   endfunction

   task automatic add_row(input req_word_type scan, input bit use_fixed,
                          input rsp_word_type fixed);
      scan_row_type row;
      row.scan      = scan;
      row.use_fixed = use_fixed;
      row.fixed     = fixed;
      directed_rows.push_back(row);
   endtask

   function automatic int pick_centre();
      if ($urandom_range(3) == 0) begin
         return CAL_POINTS[$urandom_range(6)];
      end
      return int'($urandom_range(4095));
   endfunction

   function automatic logic [RAW_W-1:0] jitter(input int centre, input int spread);
      int v;
      v = centre + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) begin
         v = 0;
      end else if (v > 4095) begin
         v = 4095;
      end
      return RAW_W'(v);
   endfunction

   // mostly noisy clusters like a real panel, some white noise and rail values
   function automatic req_word_type random_scan();
      req_word_type     s;
      int unsigned      kind;
      int               cx;
      int               cy;
      int               spread;
      logic [RAW_W-1:0] xs [NUM_SAMP];
      logic [RAW_W-1:0] ys [NUM_SAMP];
      kind   = $urandom_range(9);
      spread = int'($urandom_range(24));
      cx     = pick_centre();
      cy     = pick_centre();
      for (int i = 0; i < NUM_SAMP; i++) begin
         if (kind < 6) begin
            xs[i] = jitter(cx, spread);
            ys[i] = jitter(cy, spread);
         end else if (kind < 9) begin
            xs[i] = RAW_W'($urandom);
            ys[i] = RAW_W'($urandom);
         end else begin
            xs[i] = $urandom_range(1) ? '1 : '0;
            ys[i] = $urandom_range(1) ? '1 : '0;
         end
      end
      s.pen_down_before = ($urandom_range(9) != 0);
      s.pen_down_after  = ($urandom_range(9) != 0);
      s.x_sample_0 = xs[0];
      s.x_sample_1 = xs[1];
      s.x_sample_2 = xs[2];
      s.x_sample_3 = xs[3];
      s.x_sample_4 = xs[4];
      s.y_sample_0 = ys[0];
      s.y_sample_1 = ys[1];
      s.y_sample_2 = ys[2];
      s.y_sample_3 = ys[3];
      s.y_sample_4 = ys[4];
      return s;
   endfunction

   // ---------------------------------------------------------------- bus tasks
   // all tasks are entered and left at a falling edge with nothing yet driven in that step

   task automatic drive_scan(input req_word_type scan, input bit use_fixed,
                             input rsp_word_type fixed);
      rsp_word_type predicted;
      // idle cycle by cycle, so the idle share matches the percentage
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= scan;
      do @(posedge clock); while (req_stall);
      predicted = calibrate_scan(scan);
      expected_pixels.push_back(use_fixed ? fixed : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_expect(input logic [CSR_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, addr, '0, rdata);
      if (rdata !== CSR_DATA_W'(value)) begin
         flag_mismatch(addr == ADDR_WIDTH ? "width readback" : "height readback",
                       rdata, value);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, addr, CSR_DATA_W'(value), rdata);
      if (addr == ADDR_WIDTH) begin
         width_reg = value;
      end else begin
         height_reg = value;
      end
      csr_expect(addr, value);
   endtask

   // ---------------------------------------------------------------- result side

   // receiver pacing, with an occasional long hold-off to back the block up
   initial begin : rsp_pacing
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            flag_mismatch("result word with none pending", rsp_word, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_word.touched !== want.touched) begin
               flag_mismatch("touched", rsp_word.touched, want.touched);
            end
            if (rsp_word.screen_x !== want.screen_x) begin
               flag_mismatch("screen_x", rsp_word.screen_x, want.screen_x);
            end
            if (rsp_word.screen_y !== want.screen_y) begin
               flag_mismatch("screen_y", rsp_word.screen_y, want.screen_y);
            end
         end
      end
   end

   // watchdog: too long without any word moving on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      req_word_type scan;

      // size settings per phase; idling moves from receiver-heavy to sender-heavy to none
      phases[0] = '{12'd320,  12'd480,  13, 58, 1'b0};
      phases[1] = '{12'd1,    12'd1,    13, 58, 1'b1};
      phases[2] = '{12'd2048, 12'd2048, 13, 58, 1'b0};
      phases[3] = '{12'd0,    12'd0,    58, 13, 1'b0};
      phases[4] = '{12'd4095, 12'd4095, 58, 13, 1'b1};
      phases[5] = '{SIZE_W'($urandom_range(1, 2048)), SIZE_W'($urandom_range(1, 2048)),
                    58, 13, 1'b0};
      phases[6] = '{12'd2049, 12'd600,  0,  0,  1'b0};
      phases[7] = '{12'd320,  12'd480,  0,  0,  1'b0};

      // pen up at reset: held raw is zero, so both axes sit at their far clamp
      add_row(uniform_scan(0, 0, 2000, 2000), 1'b1, {1'b0, 11'd319, 11'd479});
      // rail-high samples land below zero on both axes
      add_row(uniform_scan(1, 1, 4095, 4095), 1'b1, {1'b1, 11'd0, 11'd0});
      // pen lifted at one check only: rejected, held values stay
      add_row(uniform_scan(1, 0, 0, 0), 1'b1, {1'b0, 11'd0, 11'd0});
      add_row(uniform_scan(0, 1, 0, 0), 1'b1, {1'b0, 11'd0, 11'd0});
      add_row(uniform_scan(1, 1, 0, 0), 1'b1, {1'b1, 11'd319, 11'd479});
      add_row(uniform_scan(0, 0, 4095, 4095), 1'b1, {1'b0, 11'd319, 11'd479});
      // calibration end points
      add_row(uniform_scan(1, 1, RAW_X_HI, CAL_Y0), 1'b1, {1'b1, 11'd0, 11'd0});
      add_row(uniform_scan(1, 1, RAW_X_LO, CAL_Y4), 1'b1, {1'b1, 11'd319, 11'd479});
      // segment boundaries and just past them
      add_row(uniform_scan(1, 1, 2068, CAL_Y1), 1'b0, '0);
      add_row(uniform_scan(1, 1, 1500, CAL_Y1 - 1), 1'b0, '0);
      add_row(uniform_scan(1, 1, 3000, CAL_Y2), 1'b0, '0);
      add_row(uniform_scan(1, 1, 1000, CAL_Y2 - 1), 1'b0, '0);
      add_row(uniform_scan(1, 1, 2500, CAL_Y3), 1'b0, '0);
      add_row(uniform_scan(1, 1, RAW_X_LO + 1, CAL_Y3 - 1), 1'b0, '0);
      add_row(uniform_scan(1, 1, RAW_X_HI - 1, CAL_Y4 - 1), 1'b0, '0);
      add_row(uniform_scan(1, 1, RAW_X_HI + 1, CAL_Y0 + 1), 1'b0, '0);
      // mean truncation with uneven samples
      scan = uniform_scan(1, 1, 0, 4095);
      scan.x_sample_1 = 12'd1;
      scan.x_sample_2 = 12'd2;
      scan.x_sample_3 = 12'd3;
      scan.x_sample_4 = 12'd4;
      scan.y_sample_4 = 12'd4094;
      add_row(scan, 1'b0, '0);
      // alternating bit patterns
      scan = uniform_scan(1, 1, 12'hAAA, 12'h555);
      scan.x_sample_1 = 12'h555;
      scan.x_sample_3 = 12'h555;
      scan.y_sample_1 = 12'hAAA;
      scan.y_sample_3 = 12'hAAA;
      add_row(scan, 1'b0, '0);
      add_row(uniform_scan(0, 0, 12'hFFF, 12'hFFF), 1'b0, '0);
      add_row(uniform_scan(1, 1, 2067, 2287), 1'b0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // size registers come out of reset at 320 x 480
      csr_expect(ADDR_WIDTH, WIDTH_RESET);
      csr_expect(ADDR_HEIGHT, HEIGHT_RESET);

      foreach (directed_rows[i]) begin
         drive_scan(directed_rows[i].scan, directed_rows[i].use_fixed, directed_rows[i].fixed);
      end

      // random scans, one size setting per phase, written with the pipe empty
      for (int p = 0; p < NUM_PHASES; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         req_idle_pct  = phases[p].req_idle_pct;
         rsp_stall_pct = phases[p].rsp_stall_pct;
         csr_write(ADDR_WIDTH, phases[p].width);
         csr_write(ADDR_HEIGHT, phases[p].height);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (phases[p].hold_off && i == HOLD_OFF_AT) begin
               hold_off_req = 1'b1;
            end
            drive_scan(random_scan(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      wait_drained();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
